FILE: hw/rtl/xbd_pkg.sv
// ----------------------------------------------------------------------------
// xbd_pkg
// Shared types and constants of the x86-64 block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package xbd_pkg;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FMT   = 3'd1;
    localparam logic [2:0] ST_UNSUP = 3'd2;
    localparam logic [2:0] ST_NOTF  = 3'd3;
    localparam logic [2:0] ST_CAP   = 3'd4;

    // ir operations
    localparam logic [3:0] OP_MOVRR = 4'd0;
    localparam logic [3:0] OP_LEA   = 4'd1;
    localparam logic [3:0] OP_MOVRI = 4'd2;
    localparam logic [3:0] OP_ADD   = 4'd3;
    localparam logic [3:0] OP_SUB   = 4'd4;
    localparam logic [3:0] OP_XOR   = 4'd5;
    localparam logic [3:0] OP_AND   = 4'd6;
    localparam logic [3:0] OP_OR    = 4'd7;
    localparam logic [3:0] OP_CMP   = 4'd8;
    localparam logic [3:0] OP_TEST  = 4'd9;
    localparam logic [3:0] OP_ADDI  = 4'd10;
    localparam logic [3:0] OP_SUBI  = 4'd11;
    localparam logic [3:0] OP_CMPI  = 4'd12;
    localparam logic [3:0] OP_BR    = 4'd13;
    localparam logic [3:0] OP_JMP   = 4'd14;
    localparam logic [3:0] OP_RET   = 4'd15;

    // commands and register indexes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;
    localparam logic [1:0] REG_BASE = 2'd0;
    localparam logic [1:0] REG_LEN  = 2'd1;
    localparam logic [1:0] REG_CAP  = 2'd2;
    localparam logic [15:0] CAP_RESET = 16'd64;

    // decode phases
    typedef enum logic [3:0] {
        PH_IDLE, PH_TOP, PH_ENDBR, PH_OPC, PH_MODRM,
        PH_DISP, PH_IMM, PH_OP2, PH_REL
    } t_phase;

    // action kinds from front to back
    typedef enum logic [1:0] {
        ACT_NONE, ACT_FAIL, ACT_EMIT
    } t_act;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  ir_op;
        logic [3:0]  dest_reg;
        logic [3:0]  src_reg;
        logic [2:0]  condition;
        logic [63:0] immediate;
        logic [63:0] branch_target;
        logic        last;
        logic [31:0] block_length;
    } t_result;

    // one classified request: an op or error, plus a trailing format error
    typedef struct packed {
        t_act       act;
        t_result    res;
        logic       term;
        logic       tail_fmt;
    } t_action;

    function automatic logic [63:0] sext8(input logic [7:0] v);
        return {{56{v[7]}}, v};
    endfunction

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/xbd_stream_if.sv
// ----------------------------------------------------------------------------
// xbd_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface xbd_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/x86_64_block_decoder.sv
// ----------------------------------------------------------------------------
// x86_64_block_decoder
// Streams code bytes of one x86-64 basic block and emits IR operations.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  i_req   | in  | command, start_pc, code_byte
//  o_res   | out | status, ir_op, dest_reg, src_reg, condition, immediate,
//          |     | branch_target, last, block_length
//  cfg     | in  | i_cfg_we, i_cfg_index, i_cfg_data
// One request per cycle while ready is high; each request is decoded in the
// cycle it is taken. Its results are offered from the action queue once the
// actions ahead of it have left; a request yields up to two results, the
// second after the first is taken. The queue holds at most three actions;
// requests stall while three wait and none leaves in that cycle. Output
// stalls fill the queue. Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_64_block_decoder import xbd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    xbd_stream_if.sink       i_req,
    xbd_stream_if.source     o_res
);

    logic [63:0] r_base;
    logic [31:0] r_len;
    logic [15:0] r_cap;
    t_action     action;
    logic        ready;
    logic        take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_len  <= '0;
            r_cap  <= CAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BASE: r_base <= i_cfg_data;
                REG_LEN:  r_len  <= i_cfg_data[31:0];
                REG_CAP:  r_cap  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign i_req.ready = ready;
    assign take = i_req.valid && ready;

    xbd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (take),
        .i_command      (i_req.data[72]),
        .i_start_pc     (i_req.data[71:8]),
        .i_code_byte    (i_req.data[7:0]),
        .i_image_base   (r_base),
        .i_image_length (r_len),
        .i_op_capacity  (r_cap),
        .o_action       (action)
    );

    xbd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (take),
        .i_action (action),
        .o_ready  (ready),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/xbd_front.sv
// ----------------------------------------------------------------------------
// xbd_front
// Byte-level decode state machine; produces one action per request.
// ----------------------------------------------------------------------------
`default_nettype none

module xbd_front import xbd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_command,
    input  wire logic [63:0] i_start_pc,
    input  wire logic [7:0]  i_code_byte,
    input  wire logic [63:0] i_image_base,
    input  wire logic [31:0] i_image_length,
    input  wire logic [15:0] i_op_capacity,
    output t_action          o_action
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_off, n_off;
    logic [63:0] r_addr, n_addr;
    logic [63:0] r_start, n_start;
    logic [2:0]  r_rex, n_rex;
    logic [15:0] r_opc, n_opc;
    logic [7:0]  r_modrm, n_modrm;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_pend, n_pend;
    logic [15:0] r_ops, n_ops;

    logic [32:0] room_base;
    logic        room1;
    logic [31:0] off1;
    logic [63:0] addr1;
    logic [7:0]  b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_off   <= '0;
            r_addr  <= '0;
            r_start <= '0;
            r_rex   <= '0;
            r_opc   <= '0;
            r_modrm <= '0;
            r_acc   <= '0;
            r_pend  <= '0;
            r_ops   <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_addr  <= n_addr;
            r_start <= n_start;
            r_rex   <= n_rex;
            r_opc   <= n_opc;
            r_modrm <= n_modrm;
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            r_ops   <= n_ops;
        end
    end

    assign b     = i_code_byte;
    assign off1  = r_off + 32'd1;
    assign addr1 = r_addr + 64'd1;
    // room(k) after consuming this byte
    assign room_base = {1'b0, off1};
    assign room1 = (room_base + 33'd1) <= {1'b0, i_image_length};

    function automatic logic room_n(input logic [31:0] off, input logic [3:0] k,
                                    input logic [31:0] len);
        return ({1'b0, off} + {29'd0, k}) <= {1'b0, len};
    endfunction

    // decode state machine, next state and action
    always_comb begin
        t_action a;
        logic [7:0]  op;
        logic [3:0]  rr, rb;
        logic        emit_it, term;
        logic [3:0]  e_op, e_d, e_s;
        logic [2:0]  e_c;
        logic [63:0] e_imm, e_tgt;
        logic        fail_it;
        logic [2:0]  f_st;
        logic        begin_next;
        logic [3:0]  coll_n;
        t_phase      coll_ph;
        logic        coll;
        logic [63:0] acc_s;
        logic [3:0]  nbytes;
        logic [63:0] fv;
        logic [3:0]  nib;
        logic [63:0] off64;
        logic        modrm_go;
        logic [7:0]  mrm;
        n_phase = r_phase;
        n_off   = r_off;
        n_addr  = r_addr;
        n_start = r_start;
        n_rex   = r_rex;
        n_opc   = r_opc;
        n_modrm = r_modrm;
        n_acc   = r_acc;
        n_pend  = r_pend;
        n_ops   = r_ops;
        a = '0;
        emit_it = 1'b0; term = 1'b0; e_op = '0; e_d = '0; e_s = '0; e_c = '0;
        e_imm = '0; e_tgt = '0; fail_it = 1'b0; f_st = ST_OK;
        coll = 1'b0; coll_n = '0; coll_ph = PH_IDLE; modrm_go = 1'b0;
        begin_next = 1'b0; rr = '0; rb = '0;
        op = r_opc[7:0];
        mrm = r_modrm;
        acc_s = '0; nbytes = '0; fv = '0; nib = '0;
        off64 = i_start_pc - i_image_base;

        if (i_command == CMD_START) begin
            n_phase = PH_IDLE;
            if (off64 >= {32'd0, i_image_length}) begin
                fail_it = 1'b1; f_st = ST_NOTF;
            end else begin
                n_off = off64[31:0]; n_addr = i_start_pc; n_start = i_start_pc;
                n_ops = '0; n_opc = '0; n_modrm = '0; n_acc = '0; n_pend = '0;
                n_rex = '0; n_phase = PH_TOP;
                if (!room_n(off64[31:0], 4'd1, i_image_length)) begin
                    fail_it = 1'b1; f_st = ST_FMT;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            if (r_off >= i_image_length) begin
                fail_it = 1'b1; f_st = ST_FMT;
            end else begin
                n_off = off1; n_addr = addr1;
                unique case (r_phase)
                    PH_TOP, PH_OPC: begin
                        if (r_phase == PH_TOP && b == 8'hF3
                                && room_n(off1, 4'd3, i_image_length)) begin
                            n_pend = 4'd3; n_phase = PH_ENDBR;
                        end else if (r_phase == PH_TOP && b >= 8'h40 && b <= 8'h4F) begin
                            n_rex = {b[3], b[2], b[0]};
                            n_phase = PH_OPC;
                            if (!room1) begin
                                fail_it = 1'b1; f_st = ST_FMT;
                            end
                        end else begin
                            n_opc = {8'd0, b};
                            unique case (b)
                                8'h89, 8'h8B, 8'h8D, 8'hC7, 8'h01, 8'h29, 8'h31,
                                8'h21, 8'h09, 8'h39, 8'h85, 8'h3B, 8'h83, 8'h81: begin
                                    if (!room1) begin
                                        fail_it = 1'b1; f_st = ST_FMT;
                                    end else n_phase = PH_MODRM;
                                end
                                8'h0F: begin
                                    if (!room1) begin
                                        fail_it = 1'b1; f_st = ST_FMT;
                                    end else n_phase = PH_OP2;
                                end
                                8'hE9: begin coll = 1'b1; coll_n = 4'd4; coll_ph = PH_REL; end
                                8'hEB: begin coll = 1'b1; coll_n = 4'd1; coll_ph = PH_REL; end
                                8'hC3: begin emit_it = 1'b1; term = 1'b1; e_op = OP_RET; end
                                default: begin
                                    if (b >= 8'hB8 && b <= 8'hBF) begin
                                        coll = 1'b1; coll_ph = PH_IMM;
                                        coll_n = n_rex[2] ? 4'd8 : 4'd4;
                                    end else if (b >= 8'h70 && b <= 8'h7F) begin
                                        coll = 1'b1; coll_n = 4'd1; coll_ph = PH_REL;
                                    end else begin
                                        fail_it = 1'b1; f_st = ST_UNSUP;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_ENDBR: begin
                        if (b != (r_pend == 4'd3 ? 8'h0F : r_pend == 4'd2 ? 8'h1E : 8'hFA))
                        begin
                            fail_it = 1'b1; f_st = ST_UNSUP;
                        end else begin
                            n_pend = r_pend - 4'd1;
                            if (r_pend == 4'd1) begin
                                n_rex = '0; n_phase = PH_TOP;
                                if (!room1) begin
                                    fail_it = 1'b1; f_st = ST_FMT;
                                end
                            end
                        end
                    end
                    PH_MODRM: begin
                        n_modrm = b; mrm = b; n_acc = '0; acc_s = '0;
                        if (b[7:6] == 2'd3) modrm_go = 1'b1;
                        else if (b[2:0] == 3'd4 || (b[2:0] == 3'd5 && b[7:6] == 2'd0)) begin
                            fail_it = 1'b1; f_st = ST_UNSUP;
                        end else if (b[7:6] == 2'd0) modrm_go = 1'b1;
                        else begin
                            coll = 1'b1; coll_ph = PH_DISP;
                            coll_n = (b[7:6] == 2'd1) ? 4'd1 : 4'd4;
                        end
                    end
                    PH_OP2: begin
                        n_opc = {b, r_opc[7:0]};
                        if (b[7:4] == 4'h8) begin
                            coll = 1'b1; coll_n = 4'd4; coll_ph = PH_REL;
                        end else begin
                            fail_it = 1'b1; f_st = ST_UNSUP;
                        end
                    end
                    PH_DISP, PH_IMM, PH_REL: begin
                        n_acc = {b, r_acc[63:8]};
                        n_pend = (r_pend != 4'd0) ? r_pend - 4'd1 : 4'd0;
                        if (n_pend == 4'd0) begin
                            if (r_phase == PH_DISP) begin
                                acc_s = (mrm[7:6] == 2'd1) ? sext8(n_acc[63:56])
                                                           : sext32(n_acc[63:32]);
                                n_acc = acc_s;
                                modrm_go = 1'b1;
                            end else if (r_phase == PH_IMM) begin
                                nbytes = (op == 8'h83) ? 4'd1
                                       : (op >= 8'hB8 && op <= 8'hBF && r_rex[2]) ? 4'd8
                                       : 4'd4;
                                fv = (nbytes == 4'd1) ? {56'd0, n_acc[63:56]}
                                   : (nbytes == 4'd4) ? {32'd0, n_acc[63:32]} : n_acc;
                                if (op >= 8'hB8 && op <= 8'hBF) begin
                                    emit_it = 1'b1; e_op = OP_MOVRI;
                                    e_d = {r_rex[0], op[2:0]}; e_imm = fv;
                                end else if (op == 8'hC7) begin
                                    emit_it = 1'b1; e_op = OP_MOVRI;
                                    e_d = {r_rex[0], mrm[2:0]}; e_imm = sext32(fv[31:0]);
                                end else begin
                                    e_d = {r_rex[0], mrm[2:0]};
                                    e_imm = (nbytes == 4'd1) ? sext8(fv[7:0])
                                                             : sext32(fv[31:0]);
                                    unique case (mrm[5:3])
                                        3'd0: begin emit_it = 1'b1; e_op = OP_ADDI; end
                                        3'd5: begin emit_it = 1'b1; e_op = OP_SUBI; end
                                        3'd7: begin emit_it = 1'b1; e_op = OP_CMPI; end
                                        default: begin fail_it = 1'b1; f_st = ST_UNSUP; end
                                    endcase
                                end
                            end else begin
                                fv = (op[7:4] == 4'h7 || op == 8'hEB)
                                   ? sext8(n_acc[63:56]) : sext32(n_acc[63:32]);
                                e_tgt = addr1 + fv;
                                term = 1'b1;
                                if (op == 8'hEB || op == 8'hE9) begin
                                    emit_it = 1'b1; e_op = OP_JMP;
                                end else begin
                                    nib = (op == 8'h0F) ? r_opc[11:8] : op[3:0];
                                    unique case (nib)
                                        4'h4: begin emit_it = 1'b1; e_c = 3'd0; end
                                        4'h5: begin emit_it = 1'b1; e_c = 3'd1; end
                                        4'hC: begin emit_it = 1'b1; e_c = 3'd2; end
                                        4'hD: begin emit_it = 1'b1; e_c = 3'd3; end
                                        4'hE: begin emit_it = 1'b1; e_c = 3'd4; end
                                        4'hF: begin emit_it = 1'b1; e_c = 3'd5; end
                                        default: begin fail_it = 1'b1; f_st = ST_UNSUP; end
                                    endcase
                                    e_op = OP_BR;
                                end
                            end
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase

                // after the modrm byte (and displacement if any)
                if (modrm_go) begin
                    rr = {r_rex[1], mrm[5:3]};
                    rb = {r_rex[0], mrm[2:0]};
                    if (op == 8'h8D) begin
                        if (mrm[7:6] == 2'd3) begin
                            fail_it = 1'b1; f_st = ST_UNSUP;
                        end else begin
                            emit_it = 1'b1; e_op = OP_LEA; e_d = rr; e_s = rb;
                            e_imm = n_acc;
                        end
                    end else if (mrm[7:6] != 2'd3) begin
                        fail_it = 1'b1; f_st = ST_UNSUP;
                    end else begin
                        emit_it = 1'b1; e_d = rb; e_s = rr;
                        unique case (op)
                            8'h89: e_op = OP_MOVRR;
                            8'h8B: begin e_op = OP_MOVRR; e_d = rr; e_s = rb; end
                            8'h01: e_op = OP_ADD;
                            8'h29: e_op = OP_SUB;
                            8'h31: e_op = OP_XOR;
                            8'h21: e_op = OP_AND;
                            8'h09: e_op = OP_OR;
                            8'h39: e_op = OP_CMP;
                            8'h85: e_op = OP_TEST;
                            8'h3B: begin e_op = OP_CMP; e_d = rr; e_s = rb; end
                            8'hC7: begin
                                emit_it = 1'b0;
                                if (mrm[5:3] != 3'd0) begin
                                    fail_it = 1'b1; f_st = ST_UNSUP;
                                end else begin
                                    coll = 1'b1; coll_n = 4'd4; coll_ph = PH_IMM;
                                end
                            end
                            default: begin
                                emit_it = 1'b0; coll = 1'b1; coll_ph = PH_IMM;
                                coll_n = (op == 8'h83) ? 4'd1 : 4'd4;
                            end
                        endcase
                    end
                end

                if (coll) begin
                    if (!room_n(off1, coll_n, i_image_length)) begin
                        fail_it = 1'b1; f_st = ST_FMT;
                    end else begin
                        n_acc = '0; n_pend = coll_n; n_phase = coll_ph;
                    end
                end
            end
        end

        // emit with capacity check
        if (emit_it && !fail_it) begin
            if (r_ops >= i_op_capacity) begin
                fail_it = 1'b1; f_st = ST_CAP;
            end else begin
                n_ops = r_ops + 16'd1;
                a.act = ACT_EMIT;
                a.term = term;
                a.res.status = ST_OK;
                a.res.ir_op = e_op;
                a.res.dest_reg = e_d;
                a.res.src_reg = e_s;
                a.res.condition = e_c;
                a.res.immediate = e_imm;
                a.res.branch_target = e_tgt;
                a.res.last = term;
                if (term) begin
                    a.res.block_length = n_addr[31:0] - r_start[31:0];
                    n_phase = PH_IDLE;
                end else begin
                    n_rex = '0; n_phase = PH_TOP;
                    a.tail_fmt = !room1;
                    if (!room1) n_phase = PH_IDLE;
                end
            end
        end
        if (fail_it) begin
            a = '0;
            a.act = ACT_FAIL;
            a.res.status = f_st;
            a.res.last = 1'b1;
            n_phase = PH_IDLE;
        end
        o_action = a;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/xbd_back.sv
// ----------------------------------------------------------------------------
// xbd_back
// Action queue and result sequencer; expands an action into its results.
// ----------------------------------------------------------------------------
`default_nettype none

module xbd_back import xbd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_action   i_action,
    output logic      o_ready,
    xbd_stream_if.source o_res
);

    localparam int DEPTH = 4;

    t_action     r_q [DEPTH];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_tail, n_tail;
    logic        pop, push;
    t_action     head;
    t_result     tail_res;

    assign head = r_q[r_rp];
    // keep one slot spare so the front may run while results drain
    assign o_ready = (r_cnt < 3'(DEPTH - 1)) || (r_cnt == 3'(DEPTH - 1) && pop);
    assign push = i_push && i_action.act != ACT_NONE;

    always_comb begin
        tail_res = '0;
        tail_res.status = ST_FMT;
        tail_res.last = 1'b1;
    end

    // output mux: op first, then trailing format error
    assign o_res.valid = r_cnt != 3'd0;
    assign o_res.data  = r_tail ? tail_res : head.res;
    assign pop = o_res.valid && o_res.ready && (r_tail || !head.tail_fmt);

    always_comb begin
        n_tail = r_tail;
        if (o_res.valid && o_res.ready) n_tail = !r_tail && head.tail_fmt;
        n_cnt = r_cnt + {2'd0, push} - {2'd0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
            r_tail <= 1'b0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= n_cnt;
            r_tail <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_action;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt < 3'(DEPTH) || pop)) else $error("queue overflow");
    a_tail_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail |-> r_cnt != 3'd0) else $error("tail without entry");
    a_tail_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail |-> head.tail_fmt) else $error("tail on wrong entry");

endmodule

`default_nettype wire
